### design/tts_pkg.sv
// Shared types and constants for the task table scheduler.
`timescale 1ns / 1ps

package tts_pkg;

  // Table size and the index and count widths that follow from it
  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int PRIO_W = 16;

  // Request kinds carried on in_tuser
  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_SCHED = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_STATS = 2'd3;

  // Policy register codes
  localparam logic [1:0] POL_RR = 2'd0;
  localparam logic [1:0] POL_FCFS = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;

  // Table write and clear commands broadcast to every cell
  typedef struct packed {
    logic wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic signed [PRIO_W-1:0] wr_prio;
    logic clr;
  } cell_ctl_t;

  // Best-so-far candidate handed from cell to cell
  typedef struct packed {
    logic vld;
    logic signed [PRIO_W-1:0] prio;
    logic [IDX_W-1:0] idx;
  } cand_t;

endpackage

### design/tts_cell.sv
// One table slot: holds its in-use bit and priority, and forwards the best candidate.
`timescale 1ns / 1ps

module tts_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [tts_pkg::IDX_W-1:0] my_idx,
  input  tts_pkg::cell_ctl_t     ctl,
  input  tts_pkg::cand_t         cand_i,
  output tts_pkg::cand_t         cand_o
);
  import tts_pkg::*;

  logic                     used_r;
  logic                     used_nxt;
  logic signed [PRIO_W-1:0] prio_r;
  cand_t                    cand_r;
  cand_t                    cand_nxt;

  // Slot contents: a clear empties it, a create at this index fills it
  always_comb begin
    used_nxt = used_r;
    if (ctl.clr) begin
      used_nxt = 1'b0;
    end else if (ctl.wr_en && (ctl.wr_idx == my_idx)) begin
      used_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_idx == my_idx)) begin
      prio_r <= ctl.wr_prio;
    end
  end

  // Strictly greater wins, so a tie keeps the lower slot seen upstream
  always_comb begin
    cand_nxt = cand_i;
    if (used_r && (!cand_i.vld || (prio_r > cand_i.prio))) begin
      cand_nxt.vld  = 1'b1;
      cand_nxt.prio = prio_r;
      cand_nxt.idx  = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
    end
  end

  assign cand_o = cand_r;

endmodule

### design/tts_chain.sv
// Row of slot cells; the tail gives the highest-priority used slot.
`timescale 1ns / 1ps

module tts_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  tts_pkg::cell_ctl_t ctl,
  output tts_pkg::cand_t     best
);
  import tts_pkg::*;

  cand_t link [SLOTS+1];

  // Head of the row sees no candidate
  assign link[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    tts_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .my_idx (IDX_W'(g)),
      .ctl    (ctl),
      .cand_i (link[g]),
      .cand_o (link[g+1])
    );
  end

  assign best = link[SLOTS];

endmodule

### design/task_table_scheduler.sv
// Task table scheduler: request control, counters and the slot cell row.
// Create, clear and stats-clear results are out in the cycle after the request is taken.
// A schedule request waits while the best candidate moves down the cell row one slot
// per cycle; the pick is made when the count reaches SLOTS and the output is free.
// One request is in work at a time; a new one is taken in the cycle the last result leaves.
// Synchronous active-low reset empties the table, zeroes counters and sets policy 0.
`timescale 1ns / 1ps

module task_table_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] task_priority, [47:16] entry_address
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [0] accepted, [1] running_valid, [5:2] running_slot,
                                  // [10:6] running_id, [15:11] task_count,
                                  // [47:16] schedule_calls, [79:48] switch_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // [1:0] policy
);
  import tts_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_SCAN = 1'b1;

  logic [0:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic             cur_vld_r, cur_vld_nxt;
  logic [31:0]      calls_r, calls_nxt;
  logic [31:0]      sw_r, sw_nxt;
  logic [1:0]       policy_r;
  logic             out_vld_r, out_vld_nxt;
  logic [79:0]      out_data_r;
  logic             acc_nxt;
  logic             out_free;
  logic             in_acc;
  logic             load;
  logic             scan_done;
  logic [IDX_W-1:0] pick;
  logic [IDX_W-1:0] rr_pick;
  logic [IDX_W:0]   id_full;
  logic signed [PRIO_W-1:0] in_prio;
  logic [31:0]      in_entry;
  cell_ctl_t        ctl;
  cand_t            best;

  assign in_prio  = in_tdata[15:0];
  assign in_entry = in_tdata[47:16];

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign scan_done = (state_r == ST_SCAN) && (cnt_r == CNT_W'(SLOTS)) && out_free;
  assign cfg_ready = 1'b1;

  // Round robin: next used slot after the current one, wrapping
  always_comb begin
    rr_pick = '0;
    if (cur_vld_r && ((CNT_W'(cur_r) + CNT_W'(1)) != used_r)) begin
      rr_pick = cur_r + IDX_W'(1);
    end
  end

  assign pick = (policy_r == POL_PRIO) ? best.idx : rr_pick;

  // Table commands to the cell row
  always_comb begin
    ctl         = '0;
    ctl.wr_prio = in_prio;
    ctl.wr_idx  = IDX_W'(used_r);
    ctl.wr_en   = in_acc && (in_tuser == MODE_CREATE) &&
                  (used_r < CNT_W'(SLOTS)) && (in_entry != 32'd0);
    ctl.clr     = in_acc && (in_tuser == MODE_CLEAR);
  end

  tts_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .best  (best)
  );

  // Request handling and scheduler state
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    used_nxt    = used_r;
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    calls_nxt   = calls_r;
    sw_nxt      = sw_r;
    acc_nxt     = 1'b0;
    load        = 1'b0;
    if (in_acc) begin
      case (in_tuser)
        MODE_CREATE: begin
          load = 1'b1;
          if (ctl.wr_en) begin
            used_nxt = used_r + CNT_W'(1);
            acc_nxt  = 1'b1;
          end
        end
        MODE_SCHED: begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
        MODE_CLEAR: begin
          load        = 1'b1;
          used_nxt    = '0;
          cur_nxt     = '0;
          cur_vld_nxt = 1'b0;
        end
        default: begin
          load      = 1'b1;
          calls_nxt = '0;
          sw_nxt    = '0;
        end
      endcase
    end else if (state_r == ST_SCAN) begin
      if (cnt_r != CNT_W'(SLOTS)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (scan_done) begin
        load      = 1'b1;
        state_nxt = ST_IDLE;
        calls_nxt = calls_r + 32'd1;
        if (used_r != '0) begin
          if (!cur_vld_r || (pick != cur_r)) begin
            sw_nxt = sw_r + 32'd1;
          end
          cur_nxt     = pick;
          cur_vld_nxt = 1'b1;
        end
      end
    end
  end

  assign out_vld_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  assign id_full     = {1'b0, cur_nxt} + (IDX_W+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      used_r    <= '0;
      cur_r     <= '0;
      cur_vld_r <= 1'b0;
      calls_r   <= '0;
      sw_r      <= '0;
      policy_r  <= POL_RR;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      used_r    <= used_nxt;
      cur_r     <= cur_nxt;
      cur_vld_r <= cur_vld_nxt;
      calls_r   <= calls_nxt;
      sw_r      <= sw_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        policy_r <= cfg_data;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r[0]     <= acc_nxt;
      out_data_r[1]     <= cur_vld_nxt;
      out_data_r[5:2]   <= cur_vld_nxt ? 4'(cur_nxt) : 4'd0;
      out_data_r[10:6]  <= cur_vld_nxt ? 5'(id_full) : 5'd0;
      out_data_r[15:11] <= 5'(used_nxt);
      out_data_r[47:16] <= calls_nxt;
      out_data_r[79:48] <= sw_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
